// ===== design/pmudf_pkg.sv =====
// Shared constants, result type and CRC helper for the frame deframer.
`default_nettype none
package pmudf_pkg;

  localparam logic [7:0]  StartByte     = 8'hA5;
  localparam logic [7:0]  EndByte       = 8'h5A;
  localparam logic [15:0] CrcPoly       = 16'hA001;
  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [15:0] LengthCeiling = 16'd65532;
  localparam logic [15:0] LengthMin     = 16'd3;
  localparam logic [15:0] ShutdownCmd   = 16'h000D;

  // Status codes carried with each result.
  localparam logic [1:0] StatusGood   = 2'd0;
  localparam logic [1:0] StatusBadCrc = 2'd1;
  localparam logic [1:0] StatusBadEnd = 2'd2;
  localparam logic [1:0] StatusBadLen = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  source_addr;
    logic [7:0]  dest_addr;
    logic [15:0] frame_number;
    logic [15:0] command_code;
    logic [15:0] extra_length;
    logic        ack_wanted;
    logic        shutdown_request;
    logic [15:0] received_crc;
  } pmudf_result_t;

  // One byte of CRC-16/MODBUS, reflected, bit by bit.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

// ===== design/pmudf_parser.sv =====
// Frame parser: phase sequencer, header capture and running CRC.
`default_nettype none
module pmudf_parser
  import pmudf_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_wdata,
  input  wire logic          step,
  input  wire logic [7:0]    rx_byte,
  output logic               res_valid,
  output pmudf_result_t      res_data
);

  localparam logic [3:0] PhHunt  = 4'd0;
  localparam logic [3:0] PhSrc   = 4'd1;
  localparam logic [3:0] PhDst   = 4'd2;
  localparam logic [3:0] PhFnLo  = 4'd3;
  localparam logic [3:0] PhFnHi  = 4'd4;
  localparam logic [3:0] PhLenLo = 4'd5;
  localparam logic [3:0] PhLenHi = 4'd6;
  localparam logic [3:0] PhCmdLo = 4'd7;
  localparam logic [3:0] PhCmdHi = 4'd8;
  localparam logic [3:0] PhExtra = 4'd9;
  localparam logic [3:0] PhAck   = 4'd10;
  localparam logic [3:0] PhCrcLo = 4'd11;
  localparam logic [3:0] PhCrcHi = 4'd12;
  localparam logic [3:0] PhEnd   = 4'd13;

  logic [15:0] max_length;
  logic [3:0]  phase, phase_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  held_source, held_source_next;
  logic [7:0]  held_dest, held_dest_next;
  logic [15:0] held_frame_number, held_frame_number_next;
  logic [15:0] held_command, held_command_next;
  logic        held_ack_flag, held_ack_flag_next;
  logic [15:0] held_crc, held_crc_next;

  logic [15:0] crc_upd;
  logic [15:0] limit;
  logic [15:0] len_full;
  logic [15:0] extra_count;
  logic [1:0]  end_status;

  assign crc_upd     = crc16_byte(running_crc, rx_byte);
  assign limit       = (max_length > LengthCeiling) ? LengthCeiling : max_length;
  assign len_full    = {rx_byte, frame_length[7:0]};
  assign extra_count = frame_length - LengthMin;

  // End-marker check wins over the CRC compare.
  always_comb begin
    if (rx_byte != EndByte) begin
      end_status = StatusBadEnd;
    end else if (held_crc != running_crc) begin
      end_status = StatusBadCrc;
    end else begin
      end_status = StatusGood;
    end
  end

  // Next-state and result logic for one received byte.
  always_comb begin
    phase_next             = phase;
    byte_count_next        = byte_count;
    frame_length_next      = frame_length;
    running_crc_next       = running_crc;
    held_source_next       = held_source;
    held_dest_next         = held_dest;
    held_frame_number_next = held_frame_number;
    held_command_next      = held_command;
    held_ack_flag_next     = held_ack_flag;
    held_crc_next          = held_crc;
    res_valid              = 1'b0;
    res_data               = '0;
    res_data.source_addr   = held_source;
    res_data.dest_addr     = held_dest;
    res_data.frame_number  = held_frame_number;

    case (phase)
      PhHunt: begin
        if (rx_byte == StartByte) begin
          running_crc_next       = CrcInit;
          held_source_next       = '0;
          held_dest_next         = '0;
          held_frame_number_next = '0;
          held_command_next      = '0;
          held_ack_flag_next     = 1'b0;
          held_crc_next          = '0;
          frame_length_next      = '0;
          byte_count_next        = '0;
          phase_next             = PhSrc;
        end
      end
      PhSrc: begin
        running_crc_next = crc_upd;
        held_source_next = rx_byte;
        phase_next       = PhDst;
      end
      PhDst: begin
        running_crc_next = crc_upd;
        held_dest_next   = rx_byte;
        phase_next       = PhFnLo;
      end
      PhFnLo: begin
        running_crc_next       = crc_upd;
        held_frame_number_next = {8'h00, rx_byte};
        phase_next             = PhFnHi;
      end
      PhFnHi: begin
        running_crc_next       = crc_upd;
        held_frame_number_next = {rx_byte, held_frame_number[7:0]};
        phase_next             = PhLenLo;
      end
      PhLenLo: begin
        running_crc_next  = crc_upd;
        frame_length_next = {8'h00, rx_byte};
        phase_next        = PhLenHi;
      end
      PhLenHi: begin
        running_crc_next  = crc_upd;
        frame_length_next = len_full;
        // A rejected length reports right away with only the header filled.
        if ((len_full < LengthMin) || (len_full > limit)) begin
          res_valid       = 1'b1;
          res_data.status = StatusBadLen;
          phase_next      = PhHunt;
        end else begin
          phase_next = PhCmdLo;
        end
      end
      PhCmdLo: begin
        running_crc_next  = crc_upd;
        held_command_next = {8'h00, rx_byte};
        phase_next        = PhCmdHi;
      end
      PhCmdHi: begin
        running_crc_next  = crc_upd;
        held_command_next = {rx_byte, held_command[7:0]};
        byte_count_next   = extra_count;
        phase_next        = (extra_count == 16'd0) ? PhAck : PhExtra;
      end
      PhExtra: begin
        running_crc_next = crc_upd;
        byte_count_next  = byte_count - 16'd1;
        if (byte_count == 16'd1) begin
          phase_next = PhAck;
        end
      end
      PhAck: begin
        running_crc_next   = crc_upd;
        held_ack_flag_next = (rx_byte != 8'h00);
        phase_next         = PhCrcLo;
      end
      PhCrcLo: begin
        held_crc_next = {8'h00, rx_byte};
        phase_next    = PhCrcHi;
      end
      PhCrcHi: begin
        held_crc_next = {rx_byte, held_crc[7:0]};
        phase_next    = PhEnd;
      end
      PhEnd: begin
        phase_next                = PhHunt;
        res_valid                 = 1'b1;
        res_data.status           = end_status;
        res_data.command_code     = held_command;
        res_data.extra_length     = extra_count;
        res_data.ack_wanted       = held_ack_flag;
        res_data.shutdown_request = (end_status == StatusGood) &&
                                    (held_command == ShutdownCmd);
        res_data.received_crc     = held_crc;
      end
      default: begin
        phase_next = PhHunt;
      end
    endcase

    if (!step) begin
      res_valid = 1'b0;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= LengthCeiling;
    end else if (cfg_we) begin
      max_length <= cfg_wdata;
    end
  end

  // Parser state, advanced once per accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PhHunt;
      byte_count        <= '0;
      frame_length      <= '0;
      running_crc       <= CrcInit;
      held_source       <= '0;
      held_dest         <= '0;
      held_frame_number <= '0;
      held_command      <= '0;
      held_ack_flag     <= 1'b0;
      held_crc          <= '0;
    end else if (step) begin
      phase             <= phase_next;
      byte_count        <= byte_count_next;
      frame_length      <= frame_length_next;
      running_crc       <= running_crc_next;
      held_source       <= held_source_next;
      held_dest         <= held_dest_next;
      held_frame_number <= held_frame_number_next;
      held_command      <= held_command_next;
      held_ack_flag     <= held_ack_flag_next;
      held_crc          <= held_crc_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/pmudf_out_buf.sv =====
// Result register with a skid stage between the parser and the output channel.
`default_nettype none
module pmudf_out_buf
  import pmudf_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  pmudf_result_t      push_data,
  output logic               room,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pmudf_result_t      out_data
);

  logic          skid_valid;
  pmudf_result_t skid_data;
  logic          drain;

  assign drain = out_valid && out_ready;
  assign room  = !skid_valid;

  // Output register and skid, refilled in arrival order.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data <= push_data;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end else begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/pmu_frame_deframer_crc16.sv =====
// Top level of the framed serial deframer with CRC-16/MODBUS check.
// A frame's result is registered in the output register, or in the skid stage.
// Throughput: one byte per cycle unless held off; parser steps once per transfer.
// Input is held off only while the skid stage behind the output register is full.
// Reset (rst, synchronous): hunting for start byte, max_length 65532, no result.
`default_nettype none
module pmu_frame_deframer_crc16
  import pmudf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [7:0]       source_addr,
  output logic [7:0]       dest_addr,
  output logic [15:0]      frame_number,
  output logic [15:0]      command_code,
  output logic [15:0]      extra_length,
  output logic             ack_wanted,
  output logic             shutdown_request,
  output logic [15:0]      received_crc
);

  logic          step;
  logic          res_valid;
  pmudf_result_t res_data;
  pmudf_result_t out_data;

  assign step = in_valid && in_ready;

  pmudf_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  pmudf_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_data),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Unpack the result onto the field ports.
  assign status           = out_data.status;
  assign source_addr      = out_data.source_addr;
  assign dest_addr        = out_data.dest_addr;
  assign frame_number     = out_data.frame_number;
  assign command_code     = out_data.command_code;
  assign extra_length     = out_data.extra_length;
  assign ack_wanted       = out_data.ack_wanted;
  assign shutdown_request = out_data.shutdown_request;
  assign received_crc     = out_data.received_crc;

endmodule
`default_nettype wire

// ===== test/pmu_frame_deframer_crc16_test.sv =====
// Testbench for the framed serial deframer: byte-level predictor, directed and random frames.
`timescale 1ns / 1ps
module pmu_frame_deframer_crc16_test;
  import pmudf_pkg::*;

  localparam int unsigned CycleLimit = 600000;

  // Parser states of the predictor.
  typedef enum logic [3:0] {
    ST_SEEK, ST_SRC, ST_DST, ST_FNUM_LO, ST_FNUM_HI, ST_LEN_LO, ST_LEN_HI,
    ST_CMD_LO, ST_CMD_HI, ST_DATA, ST_ACK, ST_CRC_LO, ST_CRC_HI, ST_TAIL
  } parse_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [7:0]  source_addr;
  logic [7:0]  dest_addr;
  logic [15:0] frame_number;
  logic [15:0] command_code;
  logic [15:0] extra_length;
  logic        ack_wanted;
  logic        shutdown_request;
  logic [15:0] received_crc;

  // Predictor state, mirroring the block after reset.
  parse_state_t parse_state = ST_SEEK;
  logic [15:0]  max_len_copy = LengthCeiling;
  logic [15:0]  crc_acc = CrcInit;
  logic [15:0]  data_left = 16'h0000;
  logic [15:0]  t_len = 16'h0000;
  logic [7:0]   t_src = 8'h00;
  logic [7:0]   t_dst = 8'h00;
  logic [15:0]  t_fnum = 16'h0000;
  logic [15:0]  t_cmd = 16'h0000;
  logic         t_ack = 1'b0;
  logic [15:0]  t_crc = 16'h0000;

  pmudf_result_t frames_due[$];

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned frame_bytes = 0;
  int unsigned sender_gap_max = 12;
  int unsigned sink_gap_max = 12;
  int unsigned stall_request = 0;

  pmu_frame_deframer_crc16 dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .source_addr      (source_addr),
    .dest_addr        (dest_addr),
    .frame_number     (frame_number),
    .command_code     (command_code),
    .extra_length     (extra_length),
    .ack_wanted       (ack_wanted),
    .shutdown_request (shutdown_request),
    .received_crc     (received_crc)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // CRC-16/MODBUS, one data bit at a time, LSB first.
  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = {1'b0, c[15:1]};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  // The register value above the ceiling behaves as the ceiling.
  function automatic logic [15:0] length_limit();
    return (max_len_copy > LengthCeiling) ? LengthCeiling : max_len_copy;
  endfunction

  // A rejected length reports only the status, address and frame number fields.
  function automatic pmudf_result_t frame_result(input logic [1:0] st, input bit full);
    pmudf_result_t r;
    r = '0;
    r.status = st;
    r.source_addr = t_src;
    r.dest_addr = t_dst;
    r.frame_number = t_fnum;
    if (full) begin
      r.command_code = t_cmd;
      r.extra_length = t_len - LengthMin;
      r.ack_wanted = t_ack;
      r.shutdown_request = (st == StatusGood) && (t_cmd == ShutdownCmd);
      r.received_crc = t_crc;
    end
    return r;
  endfunction

  // Advance the predicted parser by one accepted byte and queue any frame report.
  task automatic parse_rx_byte(input logic [7:0] b);
    if (parse_state != ST_SEEK && parse_state < ST_CRC_LO) begin
      crc_acc = crc_step(crc_acc, b);
    end
    case (parse_state)
      ST_SEEK: begin
        if (b == StartByte) begin
          crc_acc = CrcInit;
          t_src = 8'h00;
          t_dst = 8'h00;
          t_fnum = 16'h0000;
          t_cmd = 16'h0000;
          t_ack = 1'b0;
          t_crc = 16'h0000;
          t_len = 16'h0000;
          data_left = 16'h0000;
          parse_state = ST_SRC;
        end
      end
      ST_SRC: begin
        t_src = b;
        parse_state = ST_DST;
      end
      ST_DST: begin
        t_dst = b;
        parse_state = ST_FNUM_LO;
      end
      ST_FNUM_LO: begin
        t_fnum = {8'h00, b};
        parse_state = ST_FNUM_HI;
      end
      ST_FNUM_HI: begin
        t_fnum[15:8] = b;
        parse_state = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        t_len = {8'h00, b};
        parse_state = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        t_len[15:8] = b;
        if (t_len < LengthMin || t_len > length_limit()) begin
          frames_due.push_back(frame_result(StatusBadLen, 1'b0));
          parse_state = ST_SEEK;
        end else begin
          parse_state = ST_CMD_LO;
        end
      end
      ST_CMD_LO: begin
        t_cmd = {8'h00, b};
        parse_state = ST_CMD_HI;
      end
      ST_CMD_HI: begin
        t_cmd[15:8] = b;
        data_left = t_len - LengthMin;
        parse_state = (data_left == 16'h0000) ? ST_ACK : ST_DATA;
      end
      ST_DATA: begin
        data_left = data_left - 16'h0001;
        if (data_left == 16'h0000) begin
          parse_state = ST_ACK;
        end
      end
      ST_ACK: begin
        t_ack = (b != 8'h00);
        parse_state = ST_CRC_LO;
      end
      ST_CRC_LO: begin
        t_crc = {8'h00, b};
        parse_state = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        t_crc[15:8] = b;
        parse_state = ST_TAIL;
      end
      default: begin
        parse_state = ST_SEEK;
        if (b != EndByte) begin
          frames_due.push_back(frame_result(StatusBadEnd, 1'b1));
        end else if (t_crc != crc_acc) begin
          frames_due.push_back(frame_result(StatusBadCrc, 1'b1));
        end else begin
          frames_due.push_back(frame_result(StatusGood, 1'b1));
        end
      end
    endcase
  endtask

  // Offer one byte after a random idle gap and wait for its transfer.
  task automatic drive_rx_byte(input logic [7:0] b);
    int unsigned gap;
    gap = $urandom_range(0, sender_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    parse_rx_byte(b);
  endtask

  // Build a frame with a computed CRC (optionally corrupted) and send it.
  // A length the block will reject ends the frame after the length bytes.
  task automatic send_frame(input logic [7:0] src, input logic [7:0] dst,
                            input logic [15:0] fnum, input logic [15:0] len,
                            input logic [15:0] cmd, input logic [7:0] ack,
                            input logic [15:0] crc_flip, input logic [7:0] tail,
                            input int unsigned cut_after);
    logic [7:0]  frame_q[$];
    logic [15:0] crc;
    logic [7:0]  d;
    int unsigned pick;
    int unsigned n;
    frame_q.push_back(StartByte);
    frame_q.push_back(src);
    frame_q.push_back(dst);
    frame_q.push_back(fnum[7:0]);
    frame_q.push_back(fnum[15:8]);
    frame_q.push_back(len[7:0]);
    frame_q.push_back(len[15:8]);
    if (len >= LengthMin && len <= length_limit()) begin
      frame_q.push_back(cmd[7:0]);
      frame_q.push_back(cmd[15:8]);
      // Extra data leans toward the marker bytes, which must pass as plain data.
      for (int unsigned k = 3; k < len; k++) begin
        pick = $urandom_range(0, 15);
        d = (pick == 0) ? StartByte : (pick == 1) ? EndByte : 8'($urandom_range(0, 255));
        frame_q.push_back(d);
      end
      frame_q.push_back(ack);
      crc = CrcInit;
      for (int k = 1; k < frame_q.size(); k++) begin
        crc = crc_step(crc, frame_q[k]);
      end
      crc = crc ^ crc_flip;
      frame_q.push_back(crc[7:0]);
      frame_q.push_back(crc[15:8]);
      frame_q.push_back(tail);
    end
    n = (cut_after != 0 && cut_after < frame_q.size()) ? cut_after : frame_q.size();
    for (int unsigned k = 0; k < n; k++) begin
      drive_rx_byte(frame_q[k]);
    end
    frame_bytes += n;
  endtask

  // Write the length register once the block has drained.
  task automatic set_max_length(input logic [15:0] value);
    // Finish a cut-off frame under the old limit so the parser is hunting again.
    while (parse_state != ST_SEEK) begin
      drive_rx_byte(8'h00);
    end
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_len_copy = value;
  endtask

  // One random frame: mostly well formed, with noise, corruption and cut-offs mixed in.
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned noise;
    int unsigned cut;
    logic [15:0] lim;
    logic [15:0] len;
    logic [15:0] cmd;
    logic [15:0] flip;
    logic [7:0]  ack;
    logic [7:0]  tail;
    logic [7:0]  junk;
    lim = length_limit();
    // Noise between frames never holds a start byte, so no false start swallows traffic.
    noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (noise) begin
      junk = 8'($urandom_range(0, 255));
      drive_rx_byte((junk == StartByte) ? 8'h00 : junk);
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      len = 16'($urandom_range(3, 12));
    end else if (pick < 78) begin
      len = 16'($urandom_range(13, 48));
    end else if (pick < 86) begin
      len = 16'($urandom_range(0, 2));
    end else begin
      len = 16'(lim + 1 + $urandom_range(0, 65534 - lim));
    end
    cmd = ($urandom_range(0, 7) == 0) ? ShutdownCmd : 16'($urandom_range(0, 65535));
    ack = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    flip = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000;
    tail = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : EndByte;
    // Cut-off frames only while lengths are small, so resynchronizing stays short.
    cut = (lim <= 64 && $urandom_range(0, 9) == 0) ? $urandom_range(1, 10) : 0;
    send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               16'($urandom_range(0, 65535)), len, cmd, ack, flip, tail, cut);
  endtask

  // Field extremes, markers as data, and the shutdown command.
  task automatic test_field_extremes();
    drive_rx_byte(8'h00);
    drive_rx_byte(8'hFF);
    drive_rx_byte(EndByte);
    send_frame(8'h00, 8'hFF, 16'h0000, 16'd3, 16'h0000, 8'h00, 16'h0000, EndByte, 0);
    send_frame(8'hFF, 8'h00, 16'hFFFF, 16'd5, 16'hFFFF, 8'hFF, 16'h0000, EndByte, 0);
    send_frame(StartByte, StartByte, 16'hA5A5, 16'd4, 16'h00A5, 8'h01, 16'h0000, EndByte, 0);
    send_frame(8'h12, 8'h34, 16'h0102, 16'd3, ShutdownCmd, 8'h00, 16'h0000, EndByte, 0);
    send_frame(8'h56, 8'h78, 16'h0304, 16'd3, 16'h010D, 8'h80, 16'h0000, EndByte, 0);
  endtask

  // CRC mismatch, bad end marker and its precedence, and rejected lengths.
  task automatic test_error_status();
    send_frame(8'h01, 8'h02, 16'h1234, 16'd6, 16'h0042, 8'h01, 16'h8000, EndByte, 0);
    send_frame(8'h03, 8'h04, 16'h5678, 16'd3, 16'h0007, 8'h00, 16'h0001, StartByte, 0);
    send_frame(8'h05, 8'h06, 16'h9ABC, 16'd3, ShutdownCmd, 8'h01, 16'h0100, EndByte, 0);
    send_frame(8'h07, 8'h08, 16'hDEF0, 16'd3, ShutdownCmd, 8'h00, 16'h0000, 8'h00, 0);
    send_frame(8'hAA, 8'h55, 16'h0001, 16'd0, 16'h0000, 8'h00, 16'h0000, EndByte, 0);
    send_frame(8'h55, 8'hAA, 16'h8000, 16'd2, 16'h0000, 8'h00, 16'h0000, EndByte, 0);
    send_frame(8'h11, 8'h22, 16'h00FF, 16'd65533, 16'h0000, 8'h00, 16'h0000, EndByte, 0);
    send_frame(8'h33, 8'h44, 16'hFF00, 16'd65535, 16'h0000, 8'h00, 16'h0000, EndByte, 0);
    // Hunting restarts right after a rejected length.
    send_frame(8'h99, 8'h88, 16'h7777, 16'd3, 16'h0001, 8'h01, 16'h0000, EndByte, 0);
  endtask

  // Register extremes: the smallest limit, below the minimum, and above the ceiling.
  task automatic test_length_register();
    set_max_length(16'd3);
    send_frame(8'h10, 8'h20, 16'h0010, 16'd3, 16'h0003, 8'h00, 16'h0000, EndByte, 0);
    send_frame(8'h10, 8'h20, 16'h0011, 16'd4, 16'h0003, 8'h00, 16'h0000, EndByte, 0);
    set_max_length(16'd0);
    send_frame(8'h30, 8'h40, 16'h0012, 16'd3, 16'h0003, 8'h00, 16'h0000, EndByte, 0);
    set_max_length(16'd65535);
    send_frame(8'h50, 8'h60, 16'h0013, 16'd65533, 16'h0003, 8'h00, 16'h0000, EndByte, 0);
    send_frame(8'h70, 8'h80, 16'h0014, 16'd40, 16'h0004, 8'h01, 16'h0000, EndByte, 0);
    set_max_length(16'd65532);
    send_frame(8'h90, 8'hA0, 16'h0015, 16'd65533, 16'h0005, 8'h00, 16'h0000, EndByte, 0);
  endtask

  // The receiver holds off for a long stretch while short frames keep coming.
  task automatic test_backpressure();
    sender_gap_max = 0;
    stall_request = 300;
    repeat (6) begin
      send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 16'($urandom_range(0, 65535)), 16'd3, 16'($urandom_range(0, 65535)),
                 8'h01, 16'h0000, EndByte, 0);
      send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 16'($urandom_range(0, 65535)), 16'd0, 16'h0000, 8'h00, 16'h0000,
                 EndByte, 0);
    end
    sender_gap_max = 12;
  endtask

  // Random frames under several register settings.
  task automatic test_random_traffic();
    logic [15:0] phase_limits[5];
    int unsigned first_bytes;
    int unsigned first_results;
    int unsigned n_frames;
    phase_limits[0] = 16'd65532;
    phase_limits[1] = 16'd8;
    phase_limits[2] = 16'd65535;
    phase_limits[3] = 16'($urandom_range(3, 40));
    phase_limits[4] = 16'd3;
    n_frames = 0;
    foreach (phase_limits[p]) begin
      set_max_length(phase_limits[p]);
      first_bytes = frame_bytes;
      first_results = results_seen;
      while (frame_bytes - first_bytes < 40 || results_seen - first_results < 3) begin
        // Now and then either side runs without idling for a while.
        if (n_frames % 8 == 0) begin
          sender_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
          sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
        end
        send_random_frame();
        n_frames++;
      end
    end
    sender_gap_max = 12;
    sink_gap_max = 12;
  endtask

  // Result receiver: random wait before each result, or a long requested stall.
  initial begin : result_sink
    int unsigned wait_cycles;
    while (rst) @(posedge clk);
    forever begin
      if (stall_request != 0) begin
        wait_cycles = stall_request;
        stall_request = 0;
      end else begin
        wait_cycles = $urandom_range(0, sink_gap_max);
      end
      if (wait_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && stall_request == 0);
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare every result transfer with the oldest predicted frame report.
  always @(posedge clk) begin : result_check
    pmudf_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (frames_due.size() == 0) begin
        $error("result transfer with no frame report pending");
        mismatch_count++;
      end else begin
        want = frames_due.pop_front();
        check_field("status", 16'(want.status), 16'(status));
        check_field("source_addr", 16'(want.source_addr), 16'(source_addr));
        check_field("dest_addr", 16'(want.dest_addr), 16'(dest_addr));
        check_field("frame_number", want.frame_number, frame_number);
        check_field("command_code", want.command_code, command_code);
        check_field("extra_length", want.extra_length, extra_length);
        check_field("ack_wanted", 16'(want.ack_wanted), 16'(ack_wanted));
        check_field("shutdown_request", 16'(want.shutdown_request),
                    16'(shutdown_request));
        check_field("received_crc", want.received_crc, received_crc);
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_error_status();
    test_length_register();
    test_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
